// ===== design/lc3_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types, command and opcode codes and small helpers for the LC-3 core.
// ----------------------------------------------------------------------------
package lc3_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] load_addr;
    logic [15:0] load_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pc_after;
    logic [15:0] instr_done;
    logic [2:0]  cond_flags;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_addr_out;
    logic [15:0] mem_data_out;
  } out_word_t;

  // one port of the word memory
  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [15:0] wdata;
  } mem_req_t;

  // register file: one write port, two read ports
  typedef struct packed {
    logic        we;
    logic [2:0]  waddr;
    logic [15:0] wdata;
    logic [2:0]  ra;
    logic [2:0]  rb;
  } rf_req_t;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_EXEC = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ERR  = 2'd1;
  localparam logic [1:0] STATUS_TRAP = 2'd2;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [2:0] CC_P = 3'b001;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_N = 3'b100;

  localparam logic [15:0] PC_RESET = 16'h3000;

  function automatic logic [15:0] sext5(logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic logic [15:0] sext6(logic [5:0] v);
    return {{10{v[5]}}, v};
  endfunction

  function automatic logic [15:0] sext9(logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [15:0] sext11(logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

  function automatic logic [2:0] cc_of(logic [15:0] v);
    logic [2:0] c;
    if (v == 16'd0) begin
      c = CC_Z;
    end else if (v[15]) begin
      c = CC_N;
    end else begin
      c = CC_P;
    end
    return c;
  endfunction

endpackage

// ===== design/lc3_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_execute
// LC-3 core: word memory, eight registers, PC and N/Z/P flags, driven by
// load, read, execute and no-op commands with one result word per command.
// ----------------------------------------------------------------------------
//  channel  signals                          direction  carries
//  in       in_valid, in_ready, in_word      into core  one command word
//  out      out_valid, out_ready, out_word   out        one result word
//  cfg      cfg_we, cfg_wdata                into core  start address register
//
//  one command at a time; execute goes through fetch, decode, execute and
//  write-back, LDI and LDR through a memory step between execute and
//  write-back, since every memory access goes through the single memory
//  port; load and no-op go straight to write-back, read via a read step
//  reset loads the start address with its default and the PC with that value
//  a new word is taken while a result still waits; a stalled output holds
//  the core in write-back
// ----------------------------------------------------------------------------
module lc3_instruction_execute #(
  parameter int MEM_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lc3_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output lc3_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import lc3_pkg::*;

  mem_req_t    mem_req;
  rf_req_t     rf_req;
  logic [15:0] mem_rdata;
  logic [15:0] ra_data;
  logic [15:0] rb_data;
  logic [15:0] start_addr;

  // reset restores the default, so the reset PC is always the default
  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= PC_RESET;
    end else if (cfg_we) begin
      start_addr <= cfg_wdata;
    end
  end

  lc3_mem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  lc3_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .req     (rf_req),
    .rdata_a (ra_data),
    .rdata_b (rb_data)
  );

  lc3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .rf_req    (rf_req),
    .ra_data   (ra_data),
    .rb_data   (rb_data)
  );

endmodule

// ===== design/lc3_mem.sv =====
// ----------------------------------------------------------------------------
// lc3_mem
// Single-port word memory with a registered, synchronous read.
// ----------------------------------------------------------------------------
module lc3_mem #(
  parameter int MEM_WORDS = 65536
) (
  input  logic              clk,
  input  lc3_pkg::mem_req_t req,
  output logic [15:0]       rdata
);
  import lc3_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] mem [MEM_WORDS];

  // depth must be a power of two, which the block does not check; the address then wraps by dropping upper bits
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.addr[AW-1:0]];
  end

endmodule

// ===== design/lc3_regs.sv =====
// ----------------------------------------------------------------------------
// lc3_regs
// Eight general registers: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lc3_regs (
  input  logic             clk,
  input  logic             rst,
  input  lc3_pkg::rf_req_t req,
  output logic [15:0]      rdata_a,
  output logic [15:0]      rdata_b
);
  import lc3_pkg::*;

  logic [15:0] regs [8];
  logic [7:0]  valid;
  logic [15:0] qa;
  logic [15:0] qb;
  logic        va;
  logic        vb;

  always_ff @(posedge clk) begin
    if (req.we) begin
      regs[req.waddr] <= req.wdata;
    end
    qa <= regs[req.ra];
    qb <= regs[req.rb];
  end

  // a register never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      va    <= 1'b0;
      vb    <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      va <= valid[req.ra];
      vb <= valid[req.rb];
    end
  end

  assign rdata_a = va ? qa : 16'd0;
  assign rdata_b = vb ? qb : 16'd0;

endmodule

// ===== design/lc3_ctrl.sv =====
// ----------------------------------------------------------------------------
// lc3_ctrl
// Command sequencer: fetch, decode, execute, memory and write-back steps,
// program counter, condition code and the output word register.
// ----------------------------------------------------------------------------
module lc3_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lc3_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output lc3_pkg::out_word_t out_word,
  output lc3_pkg::mem_req_t  mem_req,
  input  logic [15:0]        mem_rdata,
  output lc3_pkg::rf_req_t   rf_req,
  input  logic [15:0]        ra_data,
  input  logic [15:0]        rb_data
);
  import lc3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DEC,
    S_EXE,
    S_MEM2,
    S_WB
  } state_t;

  state_t      state;
  logic [15:0] pc;
  logic [2:0]  cc;
  logic [15:0] ir;
  out_word_t   res;
  out_word_t   res_next;
  out_word_t   res_exe;

  logic        accept;
  logic        slot_free;
  logic [15:0] instr_w;
  logic [3:0]  op_w;
  logic [3:0]  op;
  logic [2:0]  dr;
  logic [15:0] pc1;
  logic [15:0] pcoff9;
  logic [15:0] base_off6;
  logic [15:0] src2;
  logic [15:0] ea;
  logic [15:0] v;
  logic        wreg;
  logic        setcc;
  logic        is_store_w;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // during decode the instruction is still on the memory read port
  assign instr_w    = (state == S_DEC) ? mem_rdata : ir;
  assign op_w       = instr_w[15:12];
  assign op         = ir[15:12];
  assign dr         = ir[11:9];
  assign pc1        = pc + 16'd1;
  assign pcoff9     = pc1 + sext9(instr_w[8:0]);
  assign base_off6  = ra_data + sext6(ir[5:0]);
  assign src2       = ir[5] ? sext5(ir[4:0]) : rb_data;
  assign is_store_w = (op_w == OP_ST) || (op_w == OP_STI) || (op_w == OP_STR);

  always_comb begin
    unique case (op)
      OP_STR:  ea = base_off6;
      OP_STI:  ea = mem_rdata;
      default: ea = pcoff9;
    endcase
  end

  // memory port
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = pc;
    mem_req.wdata = rb_data;
    unique case (state)
      S_IDLE: begin
        if (accept && in_word.cmd != CMD_EXEC) begin
          mem_req.addr  = in_word.load_addr;
          mem_req.we    = (in_word.cmd == CMD_LOAD);
          mem_req.wdata = in_word.load_data;
        end
      end
      S_DEC: begin
        mem_req.addr = pcoff9;
      end
      S_EXE: begin
        unique case (op)
          OP_LDI:  mem_req.addr = mem_rdata;
          OP_LDR:  mem_req.addr = base_off6;
          default: mem_req.addr = ea;
        endcase
        mem_req.we = (op == OP_ST) || (op == OP_STI) || (op == OP_STR);
      end
      default: mem_req.addr = pc;
    endcase
  end

  // register file port
  always_comb begin
    rf_req.ra    = instr_w[8:6];
    rf_req.rb    = is_store_w ? instr_w[11:9] : instr_w[2:0];
    rf_req.we    = (state == S_WB) && slot_free && res.reg_written;
    rf_req.waddr = res.reg_index;
    rf_req.wdata = res.reg_value;
  end

  // execute step
  always_comb begin
    res_exe              = '0;
    res_exe.status       = STATUS_OK;
    res_exe.pc_after     = pc1;
    res_exe.instr_done   = ir;
    res_exe.cond_flags   = cc;
    v                    = 16'd0;
    wreg                 = 1'b0;
    setcc                = 1'b1;
    res_exe.reg_index    = dr;
    unique case (op)
      OP_ADD: begin
        v    = ra_data + src2;
        wreg = 1'b1;
      end
      OP_AND: begin
        v    = ra_data & src2;
        wreg = 1'b1;
      end
      OP_NOT: begin
        v    = ~ra_data;
        wreg = 1'b1;
      end
      OP_BR: begin
        if (|(dr & cc)) begin
          res_exe.pc_after = pcoff9;
        end
      end
      OP_JMP: begin
        res_exe.pc_after = ra_data;
      end
      OP_JSR: begin
        // target comes from the old base value, before r7 is written
        res_exe.pc_after  = ir[11] ? (pc1 + sext11(ir[10:0])) : ra_data;
        res_exe.reg_index = 3'd7;
        v                 = pc1;
        wreg              = 1'b1;
        setcc             = 1'b0;
      end
      OP_LD: begin
        v    = mem_rdata;
        wreg = 1'b1;
      end
      OP_LDI, OP_LDR: begin
        // value lands in the memory step
        wreg = 1'b1;
      end
      OP_LEA: begin
        v    = pcoff9;
        wreg = 1'b1;
      end
      OP_ST, OP_STI, OP_STR: begin
        res_exe.mem_written  = 1'b1;
        res_exe.mem_addr_out = ea;
        res_exe.mem_data_out = rb_data;
      end
      OP_TRAP: begin
        res_exe.status = STATUS_TRAP;
      end
      default: begin
        res_exe.status = STATUS_ERR;
      end
    endcase
    if (wreg) begin
      res_exe.reg_written = 1'b1;
      res_exe.reg_value   = v;
      if (setcc) begin
        res_exe.cond_flags = cc_of(v);
      end
    end else begin
      res_exe.reg_index = 3'd0;
    end
  end

  // result word under construction
  always_comb begin
    res_next = res;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_next            = '0;
          res_next.status     = STATUS_OK;
          res_next.pc_after   = pc;
          res_next.cond_flags = cc;
          if (in_word.cmd == CMD_LOAD || in_word.cmd == CMD_READ) begin
            res_next.mem_addr_out = in_word.load_addr;
          end
          if (in_word.cmd == CMD_LOAD) begin
            res_next.mem_data_out = in_word.load_data;
          end
        end
      end
      S_READ: begin
        res_next.mem_data_out = mem_rdata;
      end
      S_EXE: begin
        res_next = res_exe;
      end
      S_MEM2: begin
        res_next.reg_value  = mem_rdata;
        res_next.cond_flags = cc_of(mem_rdata);
      end
      default: res_next = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= PC_RESET;
      cc        <= CC_Z;
      out_valid <= 1'b0;
    end else begin
      res       <= res_next;
      out_valid <= (state == S_WB && slot_free) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_word.cmd)
              CMD_LOAD: state <= S_WB;
              CMD_READ: state <= S_READ;
              CMD_EXEC: state <= S_DEC;
              default:  state <= S_WB;
            endcase
          end
        end
        S_READ: begin
          state <= S_WB;
        end
        S_DEC: begin
          ir    <= mem_rdata;
          state <= S_EXE;
        end
        S_EXE: begin
          if (op == OP_LDI || op == OP_LDR) begin
            state <= S_MEM2;
          end else begin
            state <= S_WB;
          end
        end
        S_MEM2: begin
          state <= S_WB;
        end
        S_WB: begin
          if (slot_free) begin
            pc       <= res.pc_after;
            cc       <= res.cond_flags;
            out_word <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mem_write_step: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == S_EXE || (state == S_IDLE && accept)))
    else $error("memory write outside execute or load");

  a_reg_write_step: assert property (@(posedge clk) disable iff (rst)
    rf_req.we |-> (state == S_WB && slot_free))
    else $error("register write outside write-back");

  a_cc_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(cc))
    else $error("condition code not one-hot");

  a_exec_decode: assert property (@(posedge clk) disable iff (rst)
    (accept && in_word.cmd == CMD_EXEC) |=> (state == S_DEC))
    else $error("execute command did not go to decode");

  a_wb_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && slot_free) |=> (out_valid && state == S_IDLE))
    else $error("write-back did not present a word");

endmodule

// ===== tb/lc3_exec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3_exec_checker
// Follows the core's registers, PC, flags and memory from the command words
// it accepts, predicts the result word of each command and compares every
// returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lc3_exec_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  lc3_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  lc3_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  import lc3_pkg::*;

  logic [15:0] mem_q [0:65535];
  bit          mem_set [0:65535];
  logic [15:0] gpr [0:7];
  logic [15:0] pc_q;
  logic [2:0]  cc_q;
  // written by cfg and reset; reset puts PC_RESET, not this value, in the pc
  logic [15:0] start_pc;

  out_word_t   pending_results [$];
  out_word_t   predicted;
  out_word_t   oldest;
  int          miss;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [2:0] flags_of(logic [15:0] v);
    return (v == 16'd0) ? CC_Z : (v[15] ? CC_N : CC_P);
  endfunction

  task automatic execute_cmd(input in_word_t w, output out_word_t r);
    logic [15:0]        ir, npc, src2, ea, v;
    logic signed [15:0] imm5, off6, off9, off11;
    logic [2:0]         dr, sr;
    logic               wreg, setcc, wmem;
    r = '0;
    case (w.cmd)
      CMD_LOAD: begin
        mem_q[w.load_addr]   = w.load_data;
        mem_set[w.load_addr] = 1'b1;
        r.mem_addr_out       = w.load_addr;
        r.mem_data_out       = w.load_data;
      end
      CMD_READ: begin
        r.mem_addr_out = w.load_addr;
        r.mem_data_out = mem_q[w.load_addr];
      end
      CMD_EXEC: begin
        ir    = mem_q[pc_q];
        npc   = pc_q + 16'd1;
        dr    = ir[11:9];
        sr    = ir[8:6];
        imm5  = 16'($signed(ir[4:0]));
        off6  = 16'($signed(ir[5:0]));
        off9  = 16'($signed(ir[8:0]));
        off11 = 16'($signed(ir[10:0]));
        src2  = ir[5] ? imm5 : gpr[ir[2:0]];
        wreg  = 1'b0;
        setcc = 1'b1;
        wmem  = 1'b0;
        v     = '0;
        ea    = '0;
        r.instr_done = ir;
        case (ir[15:12])
          OP_ADD: begin
            v    = gpr[sr] + src2;
            wreg = 1'b1;
          end
          OP_AND: begin
            v    = gpr[sr] & src2;
            wreg = 1'b1;
          end
          OP_NOT: begin
            v    = ~gpr[sr];
            wreg = 1'b1;
          end
          OP_BR: begin
            if ((dr & cc_q) != 3'b000) npc = npc + off9;
          end
          OP_JMP: npc = gpr[sr];
          OP_JSR: begin
            // base register is taken before r7 gets the return address
            ea    = ir[11] ? npc + off11 : gpr[sr];
            v     = npc;
            dr    = 3'd7;
            wreg  = 1'b1;
            setcc = 1'b0;
            npc   = ea;
          end
          OP_LD: begin
            ea   = npc + off9;
            v    = mem_q[ea];
            wreg = 1'b1;
          end
          OP_LDI: begin
            ea   = npc + off9;
            ea   = mem_q[ea];
            v    = mem_q[ea];
            wreg = 1'b1;
          end
          OP_LDR: begin
            ea   = gpr[sr] + off6;
            v    = mem_q[ea];
            wreg = 1'b1;
          end
          OP_LEA: begin
            v    = npc + off9;
            wreg = 1'b1;
          end
          OP_ST: begin
            ea   = npc + off9;
            wmem = 1'b1;
          end
          OP_STI: begin
            ea   = npc + off9;
            ea   = mem_q[ea];
            wmem = 1'b1;
          end
          OP_STR: begin
            ea   = gpr[sr] + off6;
            wmem = 1'b1;
          end
          OP_TRAP: r.status = STATUS_TRAP;
          default: r.status = STATUS_ERR;
        endcase
        if (wmem) begin
          mem_q[ea]      = gpr[dr];
          mem_set[ea]    = 1'b1;
          r.mem_written  = 1'b1;
          r.mem_addr_out = ea;
          r.mem_data_out = gpr[dr];
        end
        if (wreg) begin
          gpr[dr] = v;
          if (setcc) cc_q = flags_of(v);
          r.reg_written = 1'b1;
          r.reg_index   = dr;
          r.reg_value   = v;
        end
        pc_q = npc;
      end
      default: ;
    endcase
    r.pc_after   = pc_q;
    r.cond_flags = cc_q;
  endtask

  function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) gpr[i] = 16'd0;
      pc_q     = PC_RESET;
      cc_q     = CC_Z;
      start_pc = PC_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we) start_pc = cfg_wdata;
      if (in_valid && in_ready) begin
        execute_cmd(in_word, predicted);
        pending_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with no prediction waiting, actual %h", $time, out_word);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          miss = 0;
          miss += field_diff("status", 16'(oldest.status), 16'(out_word.status));
          miss += field_diff("pc_after", oldest.pc_after, out_word.pc_after);
          miss += field_diff("instr_done", oldest.instr_done, out_word.instr_done);
          miss += field_diff("cond_flags", 16'(oldest.cond_flags),
                             16'(out_word.cond_flags));
          miss += field_diff("reg_written", 16'(oldest.reg_written),
                             16'(out_word.reg_written));
          miss += field_diff("reg_index", 16'(oldest.reg_index),
                             16'(out_word.reg_index));
          miss += field_diff("reg_value", oldest.reg_value, out_word.reg_value);
          miss += field_diff("mem_written", 16'(oldest.mem_written),
                             16'(out_word.mem_written));
          miss += field_diff("mem_addr_out", oldest.mem_addr_out, out_word.mem_addr_out);
          miss += field_diff("mem_data_out", oldest.mem_data_out, out_word.mem_data_out);
          if (miss != 0) fail_count++;
        end
      end
    end
    pending <= pending_results.size();
  end

endmodule

// ===== tb/lc3_instruction_execute_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3_instruction_execute_tb
// Drives the LC-3 core with short programs, memory loads and reads and
// no-ops under changing handshake pressure; the checker beside the core
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module lc3_instruction_execute_tb;
  import lc3_pkg::*;

  localparam logic [3:0] OP_RTI = 4'd8;
  localparam logic [3:0] OP_RSV = 4'd13;
  localparam int PHASE_ITEMS  = 100;
  localparam int DIRECTED_LEN = 11;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  int          fail_count;
  int          pending;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          sent;
  logic [15:0] last_load_addr;
  logic [15:0] prog_addr;

  lc3_instruction_execute DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lc3_exec_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] rand_data();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return rand16();
    endcase
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [15:0] ir;
    ir = rand16();
    // r7 as base reaches ret and jsrr through r7
    if ($urandom_range(0, 5) == 0) ir[8:6] = 3'd7;
    return ir;
  endfunction

  function automatic logic [15:0] directed_word(int i);
    case (i)
      0: return {OP_ADD, 3'd1, 3'd0, 1'b1, 5'b10000};
      1: return {OP_ADD, 3'd2, 3'd1, 1'b1, 5'b01111};
      2: return {OP_AND, 3'd3, 3'd2, 3'b000, 3'd1};
      3: return {OP_NOT, 3'd4, 3'd3, 6'h3F};
      // no condition bits: never taken
      4: return {OP_BR, 3'b000, 9'h0FF};
      5: return {OP_LEA, 3'd5, 9'h100};
      6: return {OP_RTI, 12'h000};
      7: return {OP_RSV, 12'hFFF};
      8: return {OP_TRAP, 4'h0, 8'h25};
      // pointer word is the ldi itself
      9: return {OP_LDI, 3'd6, 9'h1FF};
      default: return {OP_JSR, 1'b0, 2'b00, 3'd7, 6'd0};
    endcase
  endfunction

  // {flag, address} of a never written word the next instruction would read
  function automatic logic [16:0] find_hole();
    logic [15:0]        ir, npc, ea;
    logic signed [15:0] off6, off9;
    bit                 need;
    ir   = u_chk.mem_q[u_chk.pc_q];
    npc  = u_chk.pc_q + 16'd1;
    off6 = 16'($signed(ir[5:0]));
    off9 = 16'($signed(ir[8:0]));
    ea   = npc + off9;
    need = 1'b0;
    case (ir[15:12])
      OP_LD: need = 1'b1;
      OP_LDI, OP_STI: begin
        need = 1'b1;
        if (u_chk.mem_set[ea]) ea = u_chk.mem_q[ea];
      end
      OP_LDR: begin
        need = 1'b1;
        ea   = u_chk.gpr[ir[8:6]] + off6;
      end
      default: need = 1'b0;
    endcase
    return {need && !u_chk.mem_set[ea], ea};
  endfunction

  function automatic logic [15:0] read_addr();
    logic [15:0] a;
    a = rand16();
    if (!u_chk.mem_set[a]) begin
      if ($urandom_range(0, 1) == 0 || !u_chk.mem_set[u_chk.pc_q]) a = last_load_addr;
      else a = u_chk.pc_q;
    end
    return a;
  endfunction

  task automatic send_word(input logic [1:0] op_cmd, input logic [15:0] addr,
                           input logic [15:0] data);
    while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    in_word  <= {op_cmd, addr, data};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    // wait so the checker state reflects this word
    @(posedge clk);
    if (op_cmd == CMD_LOAD) last_load_addr = addr;
    sent++;
  endtask

  // fetch word and operands are made valid before the execute word goes out
  task automatic exec_next();
    logic [16:0] hole;
    if (!u_chk.mem_set[u_chk.pc_q]) send_word(CMD_LOAD, u_chk.pc_q, rand_instr());
    hole = find_hole();
    while (hole[16]) begin
      send_word(CMD_LOAD, hole[15:0], rand_data());
      hole = find_hole();
    end
    send_word(CMD_EXEC, rand16(), rand16());
  endtask

  task automatic run_program(input int len);
    logic [15:0] a;
    a = u_chk.pc_q;
    for (int i = 0; i < len; i++) begin
      send_word(CMD_LOAD, a, rand_instr());
      a = a + 16'd1;
    end
    for (int i = 0; i < len; i++) exec_next();
  endtask

  task automatic write_start_pc(input logic [15:0] value);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int idle, input int stall, input logic [15:0] cfg_value);
    write_start_pc(cfg_value);
    idle_pct  = idle;
    stall_pct <= stall;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 29) == 0) begin
        while (pending != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0: send_word(CMD_NOP, rand16(), rand16());
        1: send_word(CMD_READ, read_addr(), rand16());
        2: send_word(CMD_LOAD, rand16(), rand_data());
        // runs whatever sits at the pc, data words included
        3: exec_next();
        default: run_program($urandom_range(1, 6));
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_start_pc(16'hFFFF);

    send_word(CMD_NOP, 16'hFFFF, 16'hFFFF);
    send_word(CMD_LOAD, 16'hFFFF, 16'hFFFF);
    send_word(CMD_READ, 16'hFFFF, 16'h0000);
    prog_addr = u_chk.pc_q;
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      send_word(CMD_LOAD, prog_addr, directed_word(i));
      prog_addr = prog_addr + 16'd1;
    end
    for (int i = 0; i < DIRECTED_LEN; i++) exec_next();

    random_phase(0, 0, 16'h0000);
    random_phase(74, 0, rand16());
    random_phase(0, 74, 16'h3000);
    random_phase(26, 26, rand16());

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
